// File: design/sliding_window_min_max_voltage_macros.svh
// Assertion macros shared by the sliding window min/max design
`ifndef SLIDING_WINDOW_MIN_MAX_VOLTAGE_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_VOLTAGE_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define SWMM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under synchronous active-low reset
`define SWMM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/swmm_pkg.sv
// Shared constants and types for the sliding window min/max design
`timescale 1ns / 1ps
package swmm_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int VOLT_W         = 14;
  localparam int NUM_W          = 32;
  localparam int CFG_W          = 7;
  localparam int MAX_WINDOW_DEF = 64;
  localparam int VOLT_LIMIT     = 15000;

  typedef enum logic [2:0] {
    ST_ROW       = 3'd0,
    ST_INVALID   = 3'd1,
    ST_END_OK    = 3'd2,
    ST_END_WARN  = 3'd3,
    ST_END_NONE  = 3'd4,
    ST_AFTER_END = 3'd5
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic acc_init;
  } hist_ctl_t;

endpackage

// File: design/swmm_hist.sv
// History memory with registered read and running min/max accumulator
`timescale 1ns / 1ps
module swmm_hist #(
  parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swmm_pkg::hist_ctl_t               ctl,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] wr_addr,
  input  logic [swmm_pkg::VOLT_W-1:0]       wr_data,
  input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rd_addr,
  input  logic [swmm_pkg::VOLT_W-1:0]       init_val,
  output logic [swmm_pkg::VOLT_W-1:0]       acc_min,
  output logic [swmm_pkg::VOLT_W-1:0]       acc_max
);
  import swmm_pkg::*;

  logic [VOLT_W-1:0] mem [MAX_WINDOW];
  logic [VOLT_W-1:0] rd_data_r;
  logic              rd_vld_r;
  logic [VOLT_W-1:0] min_r, max_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= ctl.rd_en;
    end
    if (ctl.acc_init) begin
      min_r <= init_val;
      max_r <= init_val;
    end else if (rd_vld_r && (rd_data_r != '0)) begin
      if (rd_data_r < min_r) min_r <= rd_data_r;
      if (rd_data_r > max_r) max_r <= rd_data_r;
    end
  end

  assign acc_min = min_r;
  assign acc_max = max_r;

endmodule

// File: design/sliding_window_min_max_voltage.sv
// Top level: sliding window min/max over voltage samples
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | input     | in_valid / in_stall  | in_sample
//  out     | output    | out_valid / out_stall| out_status, out_sample_number, out_value,
//          |           |                      | out_window_min, out_window_max
//  cfg     | input     | cfg_we               | cfg_wdata (window_size)
//
//  A row whose effective window is W > 1 passes through S_SCAN, S_DRAIN and S_PUSH:
//  one history read per cycle through the single memory read port, then drain and push.
//  Invalid samples, terminators, rows with W = 1 and items after the end finish in S_IDLE.
//  Reset is synchronous, active low; the history needs no clearing pass.
//  A result waits in the output register while out_stall is high; a new item is taken
//  only when the controller is idle and that register is free or being emptied.
`timescale 1ns / 1ps
`include "sliding_window_min_max_voltage_macros.svh"
module sliding_window_min_max_voltage #(
  parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [swmm_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output swmm_pkg::status_t                  out_status,
  output logic [swmm_pkg::NUM_W-1:0]         out_sample_number,
  output logic signed [swmm_pkg::SAMPLE_W-1:0] out_value,
  output logic [swmm_pkg::VOLT_W-1:0]        out_window_min,
  output logic [swmm_pkg::VOLT_W-1:0]        out_window_max,
  input  logic                               cfg_we,
  input  logic [swmm_pkg::CFG_W-1:0]         cfg_wdata
);
  import swmm_pkg::*;

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1) + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_PUSH} state_t;

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     win_size_r, win_size_nxt;
  logic [AW-1:0]        wp_r, wp_nxt;
  logic [NUM_W-1:0]     cnt_r, cnt_nxt;
  logic                 warn_r, warn_nxt;
  logic                 fin_r, fin_nxt;
  logic [AW-1:0]        rd_addr_r, rd_addr_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [NUM_W-1:0]     job_num_r, job_num_nxt;
  logic [SAMPLE_W-1:0]  job_value_r, job_value_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [NUM_W-1:0]     out_num_r, out_num_nxt;
  logic [SAMPLE_W-1:0]  out_value_r, out_value_nxt;
  logic [VOLT_W-1:0]    out_min_r, out_min_nxt;
  logic [VOLT_W-1:0]    out_max_r, out_max_nxt;

  hist_ctl_t            hctl;
  logic [VOLT_W-1:0]    acc_min, acc_max;

  logic                 accept, out_free;
  logic                 is_neg, is_valid;
  logic [VOLT_W-1:0]    store_val;
  logic [NUM_W-1:0]     cnt_inc;
  logic [31:0]          win32;
  logic [CW-1:0]        win_c;
  logic [AW-1:0]        wp_prev;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign is_neg    = in_sample[SAMPLE_W-1];
  assign is_valid  = !is_neg && (in_sample != '0) && (in_sample < SAMPLE_W'(VOLT_LIMIT));
  assign store_val = is_valid ? in_sample[VOLT_W-1:0] : '0;
  assign cnt_inc   = (cnt_r == '1) ? cnt_r : cnt_r + NUM_W'(1);
  assign wp_prev   = (wp_r == '0) ? AW'(MAX_WINDOW - 1) : wp_r - AW'(1);

  always_comb begin
    win32 = {{(32 - CFG_W){1'b0}}, win_size_r};
    if (win32 == 32'd0) win32 = 32'd1;
    if (win32 > 32'(MAX_WINDOW)) win32 = 32'(MAX_WINDOW);
    if (win32 > cnt_inc) win32 = cnt_inc;
    win_c = win32[CW-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    win_size_nxt  = cfg_we ? cfg_wdata : win_size_r;
    wp_nxt        = wp_r;
    cnt_nxt       = cnt_r;
    warn_nxt      = warn_r;
    fin_nxt       = fin_r;
    rd_addr_nxt   = rd_addr_r;
    rem_nxt       = rem_r;
    job_num_nxt   = job_num_r;
    job_value_nxt = job_value_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_num_nxt   = out_num_r;
    out_value_nxt = out_value_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    hctl          = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_value_nxt = in_sample;
          out_min_nxt   = '0;
          out_max_nxt   = '0;
          if (fin_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_AFTER_END;
            out_num_nxt    = cnt_r;
          end else if (is_neg) begin
            fin_nxt        = 1'b1;
            out_valid_nxt  = 1'b1;
            out_num_nxt    = cnt_r;
            if (cnt_r == '0) out_status_nxt = ST_END_NONE;
            else if (warn_r) out_status_nxt = ST_END_WARN;
            else             out_status_nxt = ST_END_OK;
          end else begin
            hctl.wr_en = 1'b1;
            wp_nxt     = (wp_r == AW'(MAX_WINDOW - 1)) ? '0 : wp_r + AW'(1);
            cnt_nxt    = cnt_inc;
            if (!is_valid) begin
              warn_nxt       = 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_INVALID;
              out_num_nxt    = cnt_inc;
            end else if (win_c == CW'(1)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_ROW;
              out_num_nxt    = cnt_inc;
              out_min_nxt    = store_val;
              out_max_nxt    = store_val;
            end else begin
              hctl.acc_init = 1'b1;
              job_num_nxt   = cnt_inc;
              job_value_nxt = in_sample;
              rd_addr_nxt   = wp_prev;
              rem_nxt       = win_c - CW'(1);
              state_nxt     = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        hctl.rd_en  = 1'b1;
        rd_addr_nxt = (rd_addr_r == '0) ? AW'(MAX_WINDOW - 1) : rd_addr_r - AW'(1);
        rem_nxt     = rem_r - CW'(1);
        if (rem_r == CW'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ROW;
          out_num_nxt    = job_num_r;
          out_value_nxt  = job_value_r;
          out_min_nxt    = acc_min;
          out_max_nxt    = acc_max;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_size_r  <= CFG_W'(1);
      wp_r        <= '0;
      cnt_r       <= '0;
      warn_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      win_size_r  <= win_size_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      warn_r      <= warn_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
    end
    rd_addr_r    <= rd_addr_nxt;
    job_num_r    <= job_num_nxt;
    job_value_r  <= job_value_nxt;
    out_status_r <= out_status_nxt;
    out_num_r    <= out_num_nxt;
    out_value_r  <= out_value_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
  end

  swmm_hist #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hctl),
    .wr_addr  (wp_r),
    .wr_data  (store_val),
    .rd_addr  (rd_addr_r),
    .init_val (store_val),
    .acc_min  (acc_min),
    .acc_max  (acc_max)
  );

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_sample_number = out_num_r;
  assign out_value         = out_value_r;
  assign out_window_min    = out_min_r;
  assign out_window_max    = out_max_r;

  `SWMM_ASSERT_NOW(a_row_order, clk, rst_n, out_valid_r && (out_status_r == ST_ROW), (out_min_r <= out_max_r) && (out_min_r != '0), "row result has bad min/max")
  `SWMM_ASSERT_NOW(a_nonrow_zero, clk, rst_n, out_valid_r && (out_status_r != ST_ROW), (out_min_r == '0) && (out_max_r == '0), "non-row result carries min/max")
  `SWMM_ASSERT_NXT(a_after_end, clk, rst_n, accept && fin_r, out_valid_r && (out_status_r == ST_AFTER_END) && (out_num_r == $past(cnt_r)), "item after end not reported")
  `SWMM_ASSERT_NXT(a_scan_hold, clk, rst_n, (state_r == S_SCAN) || (state_r == S_DRAIN), in_stall && $stable(cnt_r) && $stable(wp_r), "state moved during scan")

endmodule
